// ----- sv/bfbp_pkg.sv -----
package bfbp_pkg;

	localparam int CAPACITY    = 256;
	localparam int PTR_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] FUNC_WR_BIT  = 3'd0;
	localparam logic [2:0] FUNC_WR_BYTE = 3'd1;
	localparam logic [2:0] FUNC_RD_BIT  = 3'd2;
	localparam logic [2:0] FUNC_RD_BYTE = 3'd3;
	localparam logic [2:0] FUNC_FLUSH   = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_FEW  = 2'd2;
	localparam logic [1:0] STAT_BAD  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WRITE,
		S_READ,
		S_FLUSH,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic             data;
	} ram_wr_t;

endpackage

// ----- sv/bfbp_bit_ram.sv -----
module bfbp_bit_ram (
	input  logic                        clk,
	input  bfbp_pkg::ram_wr_t           wr,
	input  logic                        rd_en,
	input  logic [bfbp_pkg::PTR_W-1:0]  rd_addr,
	output logic                        rd_data
);

	logic mem [bfbp_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/bit_fifo_byte_packer.sv -----
// Bit FIFO with byte packing, storage in a 1-bit wide synchronous RAM, one bit per cycle.
// Each accepted item is decoded, then written or read bit by bit through the RAM, and its
// result beat is registered on the output; a flush emits one beat per byte and one for the
// final partial byte, up to the result limit. A new item is taken only once the last beat
// is pushed, and a stalled output beat holds the next item off.
// Reset: pointers, fill count and control clear at once; the bit store is not cleared.
module bit_fifo_byte_packer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic       bit_in,
	input  logic [7:0] byte_in,
	input  logic       pad_ones,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       has_data,
	output logic [1:0] status,
	output logic [8:0] fill_level,
	output logic       last
);

	localparam int PTR_W = bfbp_pkg::PTR_W;
	localparam int CNT_W = bfbp_pkg::CNT_W;
	localparam int RES_W = bfbp_pkg::RES_W;

	bfbp_pkg::state_t state_q, state_d;

	logic [2:0]       func_q;
	logic             bit_q;
	logic [7:0]       byte_q;
	logic             pad_q;

	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic [RES_W-1:0] res_cnt_q;
	logic             flushing_q;
	logic [2:0]       wr_idx_q;
	logic [3:0]       rd_left_q;
	logic [2:0]       rd_idx_q;
	logic             rd_vld_s1;
	logic [2:0]       rd_idx_s1;
	logic [7:0]       acc_q, acc_next;
	logic [1:0]       res_status_q;
	logic             res_has_q;

	logic             out_valid_q;
	logic [7:0]       data_q;
	logic             has_q;
	logic [1:0]       status_q;
	logic [8:0]       fill_q;
	logic             last_q;

	bfbp_pkg::ram_wr_t ram_wr;
	logic             rd_en;
	logic             rd_data;

	logic             accept, slot_free, push_last;
	logic             wr_en, wr_data;
	logic             rd_start;
	logic [3:0]       rd_n;
	logic [7:0]       rd_init;
	logic             res_set;
	logic [1:0]       res_stat_d;
	logic             res_has_d;
	logic             push;
	logic             flush_start;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	// in a flush the last beat is the one that empties the FIFO or hits the result limit
	assign push_last = flushing_q ?
		((res_cnt_q == RES_W'(bfbp_pkg::MAX_RESULTS - 1)) || (count_q == '0)) : 1'b1;

	assign ram_wr.en   = wr_en;
	assign ram_wr.addr = wp_q;
	assign ram_wr.data = wr_data;

	bfbp_bit_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (rp_q),
		.rd_data (rd_data)
	);

	always_comb begin
		acc_next = acc_q;
		if (rd_vld_s1) begin
			acc_next[rd_idx_s1] = rd_data;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		wr_en       = 1'b0;
		wr_data     = 1'b0;
		rd_en       = 1'b0;
		rd_start    = 1'b0;
		rd_n        = 4'd0;
		rd_init     = 8'h00;
		res_set     = 1'b0;
		res_stat_d  = bfbp_pkg::STAT_OK;
		res_has_d   = 1'b0;
		push        = 1'b0;
		flush_start = 1'b0;
		case (state_q)
			bfbp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bfbp_pkg::S_DECODE;
				end
			end
			bfbp_pkg::S_DECODE: begin
				res_set = 1'b1;
				state_d = bfbp_pkg::S_PUSH;
				case (func_q)
					bfbp_pkg::FUNC_WR_BIT: begin
						if (count_q == CNT_W'(bfbp_pkg::CAPACITY)) begin
							res_stat_d = bfbp_pkg::STAT_FULL;
						end else begin
							wr_en   = 1'b1;
							wr_data = bit_q;
						end
					end
					bfbp_pkg::FUNC_WR_BYTE: begin
						if (count_q > CNT_W'(bfbp_pkg::CAPACITY - 8)) begin
							res_stat_d = bfbp_pkg::STAT_FULL;
						end else begin
							state_d = bfbp_pkg::S_WRITE;
						end
					end
					bfbp_pkg::FUNC_RD_BIT: begin
						if (count_q == '0) begin
							res_stat_d = bfbp_pkg::STAT_FEW;
						end else begin
							res_has_d = 1'b1;
							rd_start  = 1'b1;
							rd_n      = 4'd1;
							state_d   = bfbp_pkg::S_READ;
						end
					end
					bfbp_pkg::FUNC_RD_BYTE: begin
						if (count_q < CNT_W'(8)) begin
							res_stat_d = bfbp_pkg::STAT_FEW;
						end else begin
							res_has_d = 1'b1;
							rd_start  = 1'b1;
							rd_n      = 4'd8;
							state_d   = bfbp_pkg::S_READ;
						end
					end
					bfbp_pkg::FUNC_FLUSH: begin
						if (count_q != '0) begin
							flush_start = 1'b1;
							state_d     = bfbp_pkg::S_FLUSH;
						end
					end
					default: begin
						res_stat_d = bfbp_pkg::STAT_BAD;
					end
				endcase
			end
			bfbp_pkg::S_WRITE: begin
				wr_en   = 1'b1;
				wr_data = byte_q[wr_idx_q];
				if (wr_idx_q == 3'd7) begin
					state_d = bfbp_pkg::S_PUSH;
				end
			end
			bfbp_pkg::S_READ: begin
				rd_en = 1'b1;
				if (rd_left_q == 4'd1) begin
					state_d = bfbp_pkg::S_PUSH;
				end
			end
			bfbp_pkg::S_FLUSH: begin
				res_set   = 1'b1;
				res_has_d = 1'b1;
				if (count_q >= CNT_W'(8)) begin
					rd_start = 1'b1;
					rd_n     = 4'd8;
					state_d  = bfbp_pkg::S_READ;
				end else if (count_q != '0) begin
					// final partial byte, high bits keep the pad value
					rd_start = 1'b1;
					rd_n     = count_q[3:0];
					rd_init  = pad_q ? 8'hFF : 8'h00;
					state_d  = bfbp_pkg::S_READ;
				end else begin
					state_d = bfbp_pkg::S_IDLE;
				end
			end
			bfbp_pkg::S_PUSH: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = (flushing_q && !push_last) ? bfbp_pkg::S_FLUSH : bfbp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bfbp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfbp_pkg::S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			count_q     <= '0;
			res_cnt_q   <= '0;
			flushing_q  <= 1'b0;
			wr_idx_q    <= '0;
			rd_left_q   <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				flushing_q <= 1'b0;
				res_cnt_q  <= '0;
				wr_idx_q   <= '0;
			end else if (flush_start) begin
				flushing_q <= 1'b1;
			end
			if (wr_en) begin
				wp_q    <= (wp_q == PTR_W'(bfbp_pkg::CAPACITY - 1)) ? '0 : wp_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (rd_en) begin
				rp_q    <= (rp_q == PTR_W'(bfbp_pkg::CAPACITY - 1)) ? '0 : rp_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (state_q == bfbp_pkg::S_WRITE) begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (rd_start) begin
				rd_left_q <= rd_n;
				rd_idx_q  <= '0;
			end else if (rd_en) begin
				rd_left_q <= rd_left_q - 1'b1;
				rd_idx_q  <= rd_idx_q + 1'b1;
			end
			if (push) begin
				res_cnt_q   <= res_cnt_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			bit_q  <= bit_in;
			byte_q <= byte_in;
			pad_q  <= pad_ones;
		end
		rd_idx_s1 <= rd_idx_q;
		acc_q     <= rd_start ? rd_init : acc_next;
		if (res_set) begin
			res_status_q <= res_stat_d;
			res_has_q    <= res_has_d;
		end
		if (push) begin
			data_q   <= res_has_q ? acc_next : 8'h00;
			has_q    <= res_has_q;
			status_q <= res_status_q;
			fill_q   <= 9'(count_q);
			last_q   <= push_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_q;
	assign has_data   = has_q;
	assign status     = status_q;
	assign fill_level = fill_q;
	assign last       = last_q;

endmodule

// ----- tb/fifo_result_checker.sv -----
`timescale 1ns / 1ps

module fifo_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] func,
	input  logic       bit_in,
	input  logic [7:0] byte_in,
	input  logic       pad_ones,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] data_out,
	input  logic       has_data,
	input  logic [1:0] status,
	input  logic [8:0] fill_level,
	input  logic       last,
	output int         fails,
	output int         pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic [1:0] st;
		logic [8:0] fill;
		logic       last;
	} beat_t;

	beat_t       predicted_beats[$];
	logic        bit_mem [bfbp_pkg::CAPACITY];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned bits_held;

	initial begin
		fails     = 0;
		pending   = 0;
		rd_ptr    = 0;
		wr_ptr    = 0;
		bits_held = 0;
	end

	function automatic void owe(input logic [7:0] data, input logic has,
			input logic [1:0] st, input logic lst);
		beat_t b;
		b.data = data;
		b.has  = has;
		b.st   = st;
		b.fill = bits_held[8:0];
		b.last = lst;
		predicted_beats.push_back(b);
	endfunction

	function automatic void put_bit(input logic b);
		bit_mem[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1) % bfbp_pkg::CAPACITY;
		bits_held++;
	endfunction

	function automatic logic take_bit();
		logic b;
		b = bit_mem[rd_ptr];
		rd_ptr = (rd_ptr + 1) % bfbp_pkg::CAPACITY;
		bits_held--;
		return b;
	endfunction

	function automatic logic [7:0] take_byte();
		logic [7:0] v;
		for (int i = 0; i < 8; i++)
			v[i] = take_bit();
		return v;
	endfunction

	function automatic void predict_fifo_op(input logic [2:0] f, input logic b_in,
			input logic [7:0] by_in, input logic pad);
		int         k;
		int         n;
		logic [7:0] v;
		beat_t      tail;
		case (f)
			bfbp_pkg::FUNC_WR_BIT: begin
				if (bits_held >= bfbp_pkg::CAPACITY) begin
					owe(8'h00, 1'b0, bfbp_pkg::STAT_FULL, 1'b1);
				end else begin
					put_bit(b_in);
					owe(8'h00, 1'b0, bfbp_pkg::STAT_OK, 1'b1);
				end
			end
			bfbp_pkg::FUNC_WR_BYTE: begin
				if (bits_held + 8 > bfbp_pkg::CAPACITY) begin
					owe(8'h00, 1'b0, bfbp_pkg::STAT_FULL, 1'b1);
				end else begin
					for (int i = 0; i < 8; i++)
						put_bit(by_in[i]);
					owe(8'h00, 1'b0, bfbp_pkg::STAT_OK, 1'b1);
				end
			end
			bfbp_pkg::FUNC_RD_BIT: begin
				if (bits_held == 0) begin
					owe(8'h00, 1'b0, bfbp_pkg::STAT_FEW, 1'b1);
				end else begin
					v = {7'd0, take_bit()};
					owe(v, 1'b1, bfbp_pkg::STAT_OK, 1'b1);
				end
			end
			bfbp_pkg::FUNC_RD_BYTE: begin
				if (bits_held < 8) begin
					owe(8'h00, 1'b0, bfbp_pkg::STAT_FEW, 1'b1);
				end else begin
					v = take_byte();
					owe(v, 1'b1, bfbp_pkg::STAT_OK, 1'b1);
				end
			end
			bfbp_pkg::FUNC_FLUSH: begin
				if (bits_held == 0) begin
					owe(8'h00, 1'b0, bfbp_pkg::STAT_OK, 1'b1);
				end else begin
					k = 0;
					while (k < bfbp_pkg::MAX_RESULTS && bits_held >= 8) begin
						v = take_byte();
						owe(v, 1'b1, bfbp_pkg::STAT_OK, 1'b0);
						k++;
					end
					// tail byte: leftover bits low, pad fill above
					if (k < bfbp_pkg::MAX_RESULTS && bits_held > 0) begin
						v = pad ? 8'hFF : 8'h00;
						n = bits_held;
						for (int i = 0; i < n; i++)
							v[i] = take_bit();
						owe(v, 1'b1, bfbp_pkg::STAT_OK, 1'b0);
					end
					tail = predicted_beats.pop_back();
					tail.last = 1'b1;
					predicted_beats.push_back(tail);
				end
			end
			default: begin
				owe(8'h00, 1'b0, bfbp_pkg::STAT_BAD, 1'b1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		beat_t want;
		beat_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {data_out, has_data, status, fill_level, last};
				if (predicted_beats.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected beat data=%h has=%b st=%0d fill=%0d last=%b",
							$realtime, got.data, got.has, got.st, got.fill, got.last);
				end else begin
					want = predicted_beats.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10) begin
							$write("%0t: mismatch exp data=%h has=%b st=%0d fill=%0d last=%b",
								$realtime, want.data, want.has, want.st, want.fill, want.last);
							$display(" / got data=%h has=%b st=%0d fill=%0d last=%b",
								got.data, got.has, got.st, got.fill, got.last);
						end
					end
				end
			end
			if (in_valid && in_ready)
				predict_fifo_op(func, bit_in, byte_in, pad_ones);
			pending = predicted_beats.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] FUNC_CODE_MAX = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] func;
	logic       bit_in;
	logic [7:0] byte_in;
	logic       pad_ones;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_out;
	logic       has_data;
	logic [1:0] status;
	logic [8:0] fill_level;
	logic       last;
	int         fails;
	int         pending;
	bit         idle_on = 1'b1;

	bit_fifo_byte_packer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.bit_in     (bit_in),
		.byte_in    (byte_in),
		.pad_ones   (pad_ones),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.has_data   (has_data),
		.status     (status),
		.fill_level (fill_level),
		.last       (last)
	);

	fifo_result_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.bit_in     (bit_in),
		.byte_in    (byte_in),
		.pad_ones   (pad_ones),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.has_data   (has_data),
		.status     (status),
		.fill_level (fill_level),
		.last       (last),
		.fails      (fails),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= idle_on ? ($urandom_range(0, 99) >= 6) : 1'b1;
	end

	initial begin
		#20_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send(input logic [2:0] f, input logic b, input logic [7:0] by,
			input logic p);
		int gap;
		gap = (idle_on && $urandom_range(0, 99) < 6) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		bit_in   <= b;
		byte_in  <= by;
		pad_ones <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_op(input logic [2:0] f);
		send(f, 1'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic send_mixed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			send_op(bfbp_pkg::FUNC_WR_BIT);
		else if (r < 50)
			send_op(bfbp_pkg::FUNC_WR_BYTE);
		else if (r < 65)
			send_op(bfbp_pkg::FUNC_RD_BIT);
		else if (r < 80)
			send_op(bfbp_pkg::FUNC_RD_BYTE);
		else if (r < 92)
			send_op(bfbp_pkg::FUNC_FLUSH);
		else
			send_op(3'($urandom_range(bfbp_pkg::FUNC_FLUSH + 1, FUNC_CODE_MAX)));
	endtask

	// reaches full from any level, hits both refusals, then drains 32 bytes
	task automatic fill_to_capacity();
		repeat (34) send_op(bfbp_pkg::FUNC_WR_BYTE);
		repeat (10) send_op(bfbp_pkg::FUNC_WR_BIT);
		send_op(bfbp_pkg::FUNC_FLUSH);
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = bfbp_pkg::FUNC_WR_BIT;
		bit_in   = 1'b0;
		byte_in  = 8'h00;
		pad_ones = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// empty cases, bad codes, byte extremes, both tail pads
		send(bfbp_pkg::FUNC_FLUSH, 1'b0, 8'h00, 1'b1);
		send(bfbp_pkg::FUNC_RD_BIT, 1'b1, 8'hFF, 1'b0);
		send(bfbp_pkg::FUNC_RD_BYTE, 1'b0, 8'h00, 1'b1);
		for (int f = bfbp_pkg::FUNC_FLUSH + 1; f <= FUNC_CODE_MAX; f++)
			send_op(3'(f));
		send(bfbp_pkg::FUNC_WR_BIT, 1'b1, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_WR_BIT, 1'b0, 8'hFF, 1'b1);
		send(bfbp_pkg::FUNC_RD_BYTE, 1'b1, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_RD_BIT, 1'b0, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_WR_BYTE, 1'b0, 8'hFF, 1'b0);
		send(bfbp_pkg::FUNC_WR_BYTE, 1'b1, 8'h00, 1'b1);
		send(bfbp_pkg::FUNC_WR_BYTE, 1'b0, 8'hA5, 1'b0);
		send(bfbp_pkg::FUNC_RD_BYTE, 1'b0, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_FLUSH, 1'b0, 8'h00, 1'b1);
		send(bfbp_pkg::FUNC_WR_BIT, 1'b1, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_WR_BYTE, 1'b0, 8'h5A, 1'b1);
		send(bfbp_pkg::FUNC_FLUSH, 1'b1, 8'hFF, 1'b0);
		send(bfbp_pkg::FUNC_WR_BIT, 1'b0, 8'h00, 1'b0);
		send(bfbp_pkg::FUNC_FLUSH, 1'b0, 8'h00, 1'b1);
		send(bfbp_pkg::FUNC_RD_BIT, 1'b0, 8'h00, 1'b0);

		// hold off until the block has drained completely
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (int n = 0; n < 260; n++) begin
			if (n == 100)
				fill_to_capacity();
			if (n == 130)
				idle_on = 1'b0;
			if (n == 200) begin
				idle_on = 1'b1;
				fill_to_capacity();
			end
			send_mixed();
		end

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/bfbp_pkg.sv
sv/bfbp_bit_ram.sv
sv/bit_fifo_byte_packer.sv
tb/fifo_result_checker.sv
tb/tb_top.sv
